// File: src/qubit_state_vector_engine_core_assert.svh
// ----------------------------------------------------------------------------
// State vector engine assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUBIT_STATE_VECTOR_ENGINE_CORE_ASSERT_SVH
`define QUBIT_STATE_VECTOR_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QSVE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QSVE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define QSVE_ASSERT(label, prop, msg)
`define QSVE_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// File: src/qsve_pkg.sv
// ----------------------------------------------------------------------------
// qsve_pkg
// Shared constants, datapath commands and payload types of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qsve_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_W      = 16;
  localparam int FRAC       = AMP_W - 2;
  localparam int DEPTH      = 1 << MAX_QUBITS;
  localparam int IDX_W      = MAX_QUBITS;
  localparam int QCFG_W     = 4;
  localparam int QSEL_W     = 4;
  localparam int REQ_W      = 2;
  localparam int RND_W      = 16;
  localparam int SUM_W      = 2 * AMP_W + MAX_QUBITS;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int ACC_W      = 2 * AMP_W + 2;
  localparam int DIV_W      = ROOT_W + AMP_W + 1;
  localparam int HIT_SH     = 2 * FRAC - RND_W;
  localparam int STEP_W     = $clog2(ROOT_W > AMP_W ? ROOT_W : AMP_W);

  typedef enum logic [REQ_W-1:0] {
    REQ_GATE    = 2'd0,
    REQ_CGATE   = 2'd1,
    REQ_MEASURE = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_CLR_WR,
    DP_MAC,
    DP_RND,
    DP_WORK_WR,
    DP_SQ_INIT,
    DP_SQ_STEP,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_AMP_WR,
    DP_MEAS_ACC,
    DP_MEAS_HIT
  } dp_op_e;

  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct packed {
    amp_t re;
    amp_t im;
  } cplx_t;

  typedef struct packed {
    cplx_t m00;
    cplx_t m01;
    cplx_t m10;
    cplx_t m11;
  } mat_t;

  typedef struct packed {
    dp_op_e             op;
    logic [IDX_W-1:0]   addr;
    logic [IDX_W-1:0]   partner;
    logic               row;
    logic               use_new;
    logic [STEP_W-1:0]  step;
  } cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

// File: src/qubit_state_vector_engine_core.sv
// ----------------------------------------------------------------------------
// qubit_state_vector_engine_core
// Fixed-point state vector store with gate, controlled gate and measure.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o    req, qubits, matrix, random
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_qubits_in_use_i
//   out      output     out_valid_o/out_ready_i  status_o, measured_index_o
//
// One item at a time. A gate runs a MAC pass over the active amplitudes (selected
// amplitudes are multiplied, the rest pass through), a square root of the norm sum,
// and a rescale pass that divides each amplitude (copied when the norm is zero).
// A measure scans amplitudes and, on a hit, collapses the store with a clearing pass.
// After reset a clearing pass over the whole store runs before the first item.
// A result held by out_ready_i stalls the next result; the item after it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module qubit_state_vector_engine_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [qsve_pkg::REQ_W-1:0]   req_type_i,
  input  logic [qsve_pkg::QSEL_W-1:0]  target_qubit_i,
  input  logic [qsve_pkg::QSEL_W-1:0]  control_qubit_i,
  input  qsve_pkg::amp_t               m00_re_i,
  input  qsve_pkg::amp_t               m00_im_i,
  input  qsve_pkg::amp_t               m01_re_i,
  input  qsve_pkg::amp_t               m01_im_i,
  input  qsve_pkg::amp_t               m10_re_i,
  input  qsve_pkg::amp_t               m10_im_i,
  input  qsve_pkg::amp_t               m11_re_i,
  input  qsve_pkg::amp_t               m11_im_i,
  input  logic [qsve_pkg::RND_W-1:0]   random_fraction_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qsve_pkg::QCFG_W-1:0]  cfg_qubits_in_use_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [qsve_pkg::IDX_W-1:0]   measured_index_o
);
  import qsve_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  mat_t  mat;

  always_comb begin
    mat.m00 = '{re: m00_re_i, im: m00_im_i};
    mat.m01 = '{re: m01_re_i, im: m01_im_i};
    mat.m10 = '{re: m10_re_i, im: m10_im_i};
    mat.m11 = '{re: m11_re_i, im: m11_im_i};
  end

  qsve_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .target_qubit_i      (target_qubit_i),
    .control_qubit_i     (control_qubit_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_qubits_in_use_i (cfg_qubits_in_use_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .measured_index_o    (measured_index_o),
    .cmd_o               (cmd),
    .stat_i              (stat)
  );

  qsve_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .mat_i             (mat),
    .random_fraction_i (random_fraction_i),
    .stat_o            (stat)
  );

endmodule

`default_nettype wire

// File: src/qsve_datapath.sv
// ----------------------------------------------------------------------------
// qsve_datapath
// Amplitude and work stores, complex MAC, norm sum, integer square root,
// two restoring dividers for rescaling, and the measure accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module qsve_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qsve_pkg::cmd_t   cmd_i,
  input  qsve_pkg::mat_t   mat_i,
  input  logic [qsve_pkg::RND_W-1:0] random_fraction_i,
  output qsve_pkg::stat_t  stat_o
);
  import qsve_pkg::*;

  localparam amp_t AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
  localparam amp_t AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};
  localparam amp_t AMP_ONE = amp_t'(1 << FRAC);

  cplx_t amp_mem  [DEPTH];
  cplx_t work_mem [DEPTH];

  mat_t                    mat_q;
  logic [RND_W-1:0]        rnd_q;
  cplx_t                   rda_q, rdb_q, wrd_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  cplx_t                   res_q;
  logic [SUM_W-1:0]        sum_q;
  logic [ROOT_W-1:0]       root_q;
  logic [IDX_W-1:0]        sel_q;
  logic [DIV_W-1:0]        rem_q [2];
  logic [AMP_W-1:0]        quo_q [2];
  logic                    ovf_q [2];
  logic                    neg_q [2];

  function automatic amp_t round_sat(logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] m;
    mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    m   = (mag + ACC_W'(1 << (FRAC - 1))) >> FRAC;
    if (|m[ACC_W-1:AMP_W-1]) begin
      return x[ACC_W-1] ? AMP_MIN : AMP_MAX;
    end else if (x[ACC_W-1]) begin
      return -amp_t'(m[AMP_W-1:0]);
    end else begin
      return amp_t'(m[AMP_W-1:0]);
    end
  endfunction

  function automatic logic [SUM_W-1:0] sq_mag(cplx_t a);
    logic signed [2*AMP_W-1:0] pr;
    logic signed [2*AMP_W-1:0] pi;
    pr = a.re * a.re;
    pi = a.im * a.im;
    return SUM_W'($unsigned(pr)) + SUM_W'($unsigned(pi));
  endfunction

  function automatic logic [DIV_W-1:0] div_num(amp_t v, logic [ROOT_W-1:0] r);
    logic [AMP_W-1:0] m;
    m = v[AMP_W-1] ? AMP_W'(-v) : AMP_W'(v);
    return (DIV_W'(m) << FRAC) + DIV_W'(r >> 1);
  endfunction

  function automatic amp_t div_result(logic [AMP_W-1:0] quo, logic ovf, logic neg);
    if (ovf || quo[AMP_W-1]) begin
      return neg ? AMP_MIN : AMP_MAX;
    end else if (neg) begin
      return -amp_t'(quo);
    end else begin
      return amp_t'(quo);
    end
  endfunction

  // MAC operand selection
  cplx_t                     coef, opnd, a0, a1;
  amp_t                      mx_c, mx_y1, mx_y2;
  logic signed [2*AMP_W-1:0] p1, p2;
  logic signed [ACC_W-1:0]   acc_re_n, acc_im_n;

  always_comb begin
    a0 = cmd_i.row ? rdb_q : rda_q;
    a1 = cmd_i.row ? rda_q : rdb_q;
    if (cmd_i.step[1]) begin
      coef = cmd_i.row ? mat_q.m11 : mat_q.m01;
      opnd = a1;
    end else begin
      coef = cmd_i.row ? mat_q.m10 : mat_q.m00;
      opnd = a0;
    end
    mx_c  = cmd_i.step[0] ? coef.im : coef.re;
    mx_y1 = cmd_i.step[0] ? opnd.im : opnd.re;
    mx_y2 = cmd_i.step[0] ? opnd.re : opnd.im;
    p1 = mx_c * mx_y1;
    p2 = mx_c * mx_y2;
    acc_re_n = (cmd_i.step[1:0] == 2'd0) ? '0 : acc_re_q;
    acc_im_n = (cmd_i.step[1:0] == 2'd0) ? '0 : acc_im_q;
    acc_re_n = cmd_i.step[0] ? acc_re_n - ACC_W'(p1) : acc_re_n + ACC_W'(p1);
    acc_im_n = acc_im_n + ACC_W'(p2);
  end

  // Norm / cumulative sum and square root trial
  cplx_t               sq_src;
  logic [SUM_W-1:0]    sum_n;
  logic [ROOT_W-1:0]   cand;
  logic [SUM_W-1:0]    cand_sq;
  logic [SUM_W-1:0]    rnd_scaled;

  always_comb begin
    sq_src     = (cmd_i.op == DP_MEAS_ACC) ? rda_q : res_q;
    sum_n      = sum_q + sq_mag(sq_src);
    cand       = root_q | (ROOT_W'(1) << cmd_i.step);
    cand_sq    = SUM_W'(cand) * SUM_W'(cand);
    rnd_scaled = SUM_W'(rnd_q) << HIT_SH;
  end

  // Divider lanes: lane 0 real, lane 1 imaginary
  logic [DIV_W-1:0] num0, num1, dsh;

  always_comb begin
    num0 = div_num(wrd_q.re, root_q);
    num1 = div_num(wrd_q.im, root_q);
    dsh  = DIV_W'(root_q) << cmd_i.step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (cmd_i.op == DP_MEAS_HIT) begin
      sel_q <= cmd_i.addr;
    end
  end

  always_ff @(posedge clk_i) begin
    rda_q <= amp_mem[cmd_i.addr];
    rdb_q <= amp_mem[cmd_i.partner];
    wrd_q <= work_mem[cmd_i.addr];
    case (cmd_i.op)
      DP_LATCH: begin
        mat_q <= mat_i;
        rnd_q <= random_fraction_i;
        sum_q <= '0;
      end
      DP_CLR_WR: begin
        amp_mem[cmd_i.addr] <= (cmd_i.addr == sel_q) ? cplx_t'{re: AMP_ONE, im: '0} : '0;
      end
      DP_MAC: begin
        acc_re_q <= acc_re_n;
        acc_im_q <= acc_im_n;
      end
      DP_RND: begin
        res_q <= cmd_i.use_new ? cplx_t'{re: round_sat(acc_re_q), im: round_sat(acc_im_q)}
                               : rda_q;
      end
      DP_WORK_WR: begin
        work_mem[cmd_i.addr] <= res_q;
        sum_q <= sum_n;
      end
      DP_SQ_INIT: begin
        root_q <= '0;
      end
      DP_SQ_STEP: begin
        if (cand_sq <= sum_q) begin
          root_q <= cand;
        end
      end
      DP_DIV_LOAD: begin
        rem_q[0] <= num0;
        rem_q[1] <= num1;
        quo_q[0] <= '0;
        quo_q[1] <= '0;
        ovf_q[0] <= num0 >= (DIV_W'(root_q) << AMP_W);
        ovf_q[1] <= num1 >= (DIV_W'(root_q) << AMP_W);
        neg_q[0] <= wrd_q.re[AMP_W-1];
        neg_q[1] <= wrd_q.im[AMP_W-1];
      end
      DP_DIV_STEP: begin
        if (rem_q[0] >= dsh) begin
          rem_q[0] <= rem_q[0] - dsh;
          quo_q[0][cmd_i.step[$clog2(AMP_W)-1:0]] <= 1'b1;
        end
        if (rem_q[1] >= dsh) begin
          rem_q[1] <= rem_q[1] - dsh;
          quo_q[1][cmd_i.step[$clog2(AMP_W)-1:0]] <= 1'b1;
        end
      end
      DP_AMP_WR: begin
        if (sum_q == '0) begin
          amp_mem[cmd_i.addr] <= wrd_q;
        end else begin
          amp_mem[cmd_i.addr] <= '{re: div_result(quo_q[0], ovf_q[0], neg_q[0]),
                                   im: div_result(quo_q[1], ovf_q[1], neg_q[1])};
        end
      end
      DP_MEAS_ACC: begin
        sum_q <= sum_n;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.sum_zero = (sum_q == '0);
  assign stat_o.hit      = (rnd_scaled <= sum_q);

endmodule

`default_nettype wire

// File: src/qsve_ctrl.sv
// ----------------------------------------------------------------------------
// qsve_ctrl
// Request decode, pass sequencing over the store, configuration register
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "qubit_state_vector_engine_core_assert.svh"

module qsve_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [qsve_pkg::REQ_W-1:0]   req_type_i,
  input  logic [qsve_pkg::QSEL_W-1:0]  target_qubit_i,
  input  logic [qsve_pkg::QSEL_W-1:0]  control_qubit_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qsve_pkg::QCFG_W-1:0]  cfg_qubits_in_use_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [qsve_pkg::IDX_W-1:0]   measured_index_o,
  output qsve_pkg::cmd_t               cmd_o,
  input  qsve_pkg::stat_t              stat_i
);
  import qsve_pkg::*;

  localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(3);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_G_RD, S_G_MAC, S_G_RND, S_G_WR, S_SQ_INIT, S_SQ_STEP,
    S_C_RD, S_C_LOAD, S_C_DIV, S_C_WR, S_M_RD, S_M_ACC, S_M_CHK, S_DONE
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   idx_q;
  logic [STEP_W-1:0]  step_q;
  logic [IDX_W-1:0]   tmask_q, cmask_q;
  logic [QCFG_W-1:0]  qcfg_q;
  logic               from_meas_q;
  logic               res_status_q;
  logic [IDX_W-1:0]   res_idx_q;
  logic               out_valid_q;
  logic               status_q;
  logic [IDX_W-1:0]   meas_idx_q;

  logic [QCFG_W-1:0]  qeff;
  logic [IDX_W-1:0]   last_idx;
  logic               sel;
  logic               bad_gate;

  always_comb begin
    if (qcfg_q == '0) begin
      qeff = QCFG_W'(1);
    end else if (qcfg_q > QCFG_W'(MAX_QUBITS)) begin
      qeff = QCFG_W'(MAX_QUBITS);
    end else begin
      qeff = qcfg_q;
    end
    last_idx = ~({IDX_W{1'b1}} << qeff);
    sel      = ((idx_q & cmask_q) == cmask_q);
    bad_gate = (target_qubit_i >= qeff) ||
               ((req_type_i == REQ_CGATE) &&
                ((control_qubit_i >= qeff) || (control_qubit_i == target_qubit_i)));
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign measured_index_o = meas_idx_q;

  always_comb begin
    cmd_o.addr    = idx_q;
    cmd_o.partner = idx_q ^ tmask_q;
    cmd_o.row     = |(idx_q & tmask_q);
    cmd_o.use_new = sel;
    cmd_o.step    = step_q;
    case (state_q)
      S_IDLE:    cmd_o.op = in_valid_i ? DP_LATCH : DP_NOP;
      S_CLEAR:   cmd_o.op = DP_CLR_WR;
      S_G_MAC:   cmd_o.op = DP_MAC;
      S_G_RND:   cmd_o.op = DP_RND;
      S_G_WR:    cmd_o.op = DP_WORK_WR;
      S_SQ_INIT: cmd_o.op = DP_SQ_INIT;
      S_SQ_STEP: cmd_o.op = DP_SQ_STEP;
      S_C_LOAD:  cmd_o.op = DP_DIV_LOAD;
      S_C_DIV:   cmd_o.op = DP_DIV_STEP;
      S_C_WR:    cmd_o.op = DP_AMP_WR;
      S_M_ACC:   cmd_o.op = DP_MEAS_ACC;
      S_M_CHK:   cmd_o.op = stat_i.hit ? DP_MEAS_HIT : DP_NOP;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      step_q       <= '0;
      tmask_q      <= '0;
      cmask_q      <= '0;
      qcfg_q       <= QCFG_W'(MAX_QUBITS);
      from_meas_q  <= 1'b0;
      res_status_q <= 1'b0;
      res_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= 1'b0;
      meas_idx_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        qcfg_q <= cfg_qubits_in_use_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (idx_q == '1) begin
            idx_q       <= '0;
            from_meas_q <= 1'b0;
            state_q     <= from_meas_q ? S_DONE : S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            res_status_q <= ((req_type_i == REQ_GATE) || (req_type_i == REQ_CGATE)) &&
                            bad_gate;
            res_idx_q    <= '0;
            idx_q        <= '0;
            case (req_type_i)
              REQ_GATE, REQ_CGATE: begin
                if (bad_gate) begin
                  state_q      <= S_DONE;
                end else begin
                  tmask_q <= IDX_W'(1) << target_qubit_i;
                  cmask_q <= (req_type_i == REQ_CGATE) ? IDX_W'(1) << control_qubit_i : '0;
                  state_q <= S_G_RD;
                end
              end
              REQ_MEASURE: state_q <= S_M_RD;
              default:     state_q <= S_DONE;
            endcase
          end
        end
        S_G_RD: begin
          step_q  <= '0;
          state_q <= sel ? S_G_MAC : S_G_RND;
        end
        S_G_MAC: begin
          if (step_q == MAC_LAST) begin
            state_q <= S_G_RND;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_G_RND: state_q <= S_G_WR;
        S_G_WR: begin
          if (idx_q == last_idx) begin
            state_q <= S_SQ_INIT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_G_RD;
          end
        end
        S_SQ_INIT: begin
          step_q  <= STEP_W'(ROOT_W - 1);
          state_q <= S_SQ_STEP;
        end
        S_SQ_STEP: begin
          if (step_q == '0) begin
            idx_q   <= '0;
            state_q <= S_C_RD;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_C_RD: state_q <= stat_i.sum_zero ? S_C_WR : S_C_LOAD;
        S_C_LOAD: begin
          step_q  <= STEP_W'(AMP_W - 1);
          state_q <= S_C_DIV;
        end
        S_C_DIV: begin
          if (step_q == '0) begin
            state_q <= S_C_WR;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_C_WR: begin
          if (idx_q == last_idx) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_C_RD;
          end
        end
        S_M_RD:  state_q <= S_M_ACC;
        S_M_ACC: state_q <= S_M_CHK;
        S_M_CHK: begin
          if (stat_i.hit) begin
            res_idx_q   <= idx_q;
            idx_q       <= '0;
            from_meas_q <= 1'b1;
            state_q     <= S_CLEAR;
          end else if (idx_q == last_idx) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_M_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            meas_idx_q  <= res_idx_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `QSVE_ASSERT(a_clear_blocks_input, (state_q == S_CLEAR) |-> !in_ready_o, "input taken during clear")
  `QSVE_ASSERT(a_error_zero_index, (out_valid_q && status_q) |-> (meas_idx_q == '0), "error with index")
  `QSVE_ASSERT(a_hit_starts_clear, (state_q == S_M_CHK && stat_i.hit) |=> (state_q == S_CLEAR && idx_q == '0), "hit did not collapse")
  `QSVE_ASSERT_NEVER(a_idx_in_range, (state_q == S_G_WR || state_q == S_C_WR || state_q == S_M_CHK) && ((idx_q & ~last_idx) != '0), "index beyond active range")

endmodule

`default_nettype wire
